>>> sv/qmn_pkg.sv
// Shared widths, constants and types for the normalised quaternion product.
package qmn_pkg;

    localparam int COMP_WIDTH   = 16;
    localparam int FRAC_BITS    = 14;
    localparam int NEWTON_STEPS = 3;

    localparam int PROD_W = 2 * COMP_WIDTH;
    localparam int SUM_W  = PROD_W + 3;
    localparam int C_W    = SUM_W - FRAC_BITS;
    localparam int SQ_W   = 2 * C_W;
    localparam int S_W    = SQ_W + 2;
    localparam int SH_OFF = S_W + (S_W % 2);
    localparam int SHL_W  = S_W + 30 + SH_OFF;
    localparam int E_W    = 7;
    localparam int T_W    = 7;
    localparam int M_W    = 30;
    localparam int Y_W    = 32;
    localparam int Q_W    = 33;
    localparam int SP_W   = C_W + Y_W;
    localparam int RS_W   = SP_W + 1;
    localparam int NS     = 2 + 3 * NEWTON_STEPS;
    localparam int QDEPTH = 4;
    localparam int QA_W   = 2;

    localparam int IN_W  = 8 * COMP_WIDTH;
    localparam int OUT_W = 4 * COMP_WIDTH;

    localparam int T_BASE = 45 - FRAC_BITS + SH_OFF / 2;

    typedef struct packed {
        logic [3:0][C_W-1:0] c;
        logic [S_W-1:0]      s;
    } t_item;

    typedef struct packed {
        logic [3:0][C_W-1:0] c;
        logic [T_W-1:0]      t;
        logic                zero;
    } t_ctx;

endpackage

>>> sv/qmn_front.sv
// Front part: Hamilton product, rounding to components and squared norm.
module qmn_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [qmn_pkg::IN_W-1:0]        i_data,
    output logic                            o_valid,
    input  logic                            i_ready,
    output qmn_pkg::t_item                  o_item
);

    logic [3:0] r_v;
    logic       en;

    logic signed [qmn_pkg::COMP_WIDTH-1:0] a [4];
    logic signed [qmn_pkg::COMP_WIDTH-1:0] b [4];

    logic signed [qmn_pkg::PROD_W-1:0] r_p [4][4];
    logic signed [qmn_pkg::SUM_W-1:0]  psum [4];
    logic signed [qmn_pkg::SUM_W-1:0]  prnd [4];
    logic signed [qmn_pkg::C_W-1:0]    r_c1 [4];
    logic signed [qmn_pkg::C_W-1:0]    r_c2 [4];
    logic signed [qmn_pkg::SQ_W-1:0]   sq [4];
    logic [qmn_pkg::SQ_W-1:0]          r_sq [4];
    logic [qmn_pkg::S_W-1:0]           ssum;
    qmn_pkg::t_item                    r_item;

    assign en      = !r_v[3] || i_ready;
    assign o_ready = en;
    assign o_valid = r_v[3];
    assign o_item  = r_item;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            a[i] = $signed(i_data[i*qmn_pkg::COMP_WIDTH +: qmn_pkg::COMP_WIDTH]);
            b[i] = $signed(i_data[(i+4)*qmn_pkg::COMP_WIDTH +: qmn_pkg::COMP_WIDTH]);
        end
    end

    // w = 0, x = 1, y = 2, z = 3
    always_comb begin
        psum[0] = qmn_pkg::SUM_W'(r_p[0][0]) - qmn_pkg::SUM_W'(r_p[1][1])
                - qmn_pkg::SUM_W'(r_p[2][2]) - qmn_pkg::SUM_W'(r_p[3][3]);
        psum[1] = qmn_pkg::SUM_W'(r_p[0][1]) + qmn_pkg::SUM_W'(r_p[1][0])
                + qmn_pkg::SUM_W'(r_p[2][3]) - qmn_pkg::SUM_W'(r_p[3][2]);
        psum[2] = qmn_pkg::SUM_W'(r_p[0][2]) + qmn_pkg::SUM_W'(r_p[2][0])
                + qmn_pkg::SUM_W'(r_p[3][1]) - qmn_pkg::SUM_W'(r_p[1][3]);
        psum[3] = qmn_pkg::SUM_W'(r_p[0][3]) + qmn_pkg::SUM_W'(r_p[3][0])
                + qmn_pkg::SUM_W'(r_p[1][2]) - qmn_pkg::SUM_W'(r_p[2][1]);
        for (int i = 0; i < 4; i++) begin
            prnd[i] = psum[i] + qmn_pkg::SUM_W'(1 << (qmn_pkg::FRAC_BITS - 1));
            sq[i]   = r_c1[i] * r_c1[i];
        end
        ssum = qmn_pkg::S_W'(r_sq[0]) + qmn_pkg::S_W'(r_sq[1])
             + qmn_pkg::S_W'(r_sq[2]) + qmn_pkg::S_W'(r_sq[3]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r_p[i][j] <= a[i] * b[j];
                end
                r_c1[i]     <= prnd[i][qmn_pkg::SUM_W-1:qmn_pkg::FRAC_BITS];
                r_c2[i]     <= r_c1[i];
                r_sq[i]     <= sq[i];
                r_item.c[i] <= r_c2[i];
            end
            r_item.s <= ssum;
        end
    end

endmodule

>>> sv/qmn_queue.sv
// Short queue between the front and back parts.
module qmn_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  qmn_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output qmn_pkg::t_item o_item
);

    qmn_pkg::t_item            r_mem [qmn_pkg::QDEPTH];
    logic [qmn_pkg::QA_W-1:0]  r_wp;
    logic [qmn_pkg::QA_W-1:0]  r_rp;
    logic [qmn_pkg::QA_W:0]    r_cnt;
    logic                      push;
    logic                      pop;

    assign o_ready = r_cnt != (qmn_pkg::QA_W + 1)'(qmn_pkg::QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_item  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (qmn_pkg::QA_W + 1)'(qmn_pkg::QDEPTH))
        else $error("queue count beyond depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("push without pop did not grow queue");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0 || r_cnt == (qmn_pkg::QA_W + 1)'(qmn_pkg::QDEPTH)) |-> r_wp == r_rp)
        else $error("queue pointers disagree with count");

endmodule

>>> sv/qmn_back.sv
// Back part: normalisation, Newton reciprocal square root, scaling and saturation.
module qmn_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  qmn_pkg::t_item               i_item,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [qmn_pkg::OUT_W-1:0]    o_data
);

    localparam int NS  = qmn_pkg::NS;
    localparam int CW  = qmn_pkg::COMP_WIDTH;

    logic en;

    logic [NS-1:0]             r_v;
    qmn_pkg::t_ctx             r_ctx [NS];
    logic [qmn_pkg::M_W-1:0]   r_m   [NS];
    logic [qmn_pkg::Y_W-1:0]   r_y   [1:NS-1];
    logic [qmn_pkg::Q_W-1:0]   r_aux [2:NS-1];

    logic [qmn_pkg::E_W-1:0]   k;
    logic [qmn_pkg::E_W-1:0]   e_raw;
    logic [qmn_pkg::E_W-1:0]   e;
    logic [qmn_pkg::SHL_W-1:0] shl;
    qmn_pkg::t_ctx             ctx0;
    logic [qmn_pkg::M_W-1:0]   m0;
    logic [qmn_pkg::M_W+2:0]   m5;

    logic                      r_sv;
    qmn_pkg::t_ctx             r_sctx;
    logic [qmn_pkg::SP_W-1:0]  r_sp [4];
    logic [qmn_pkg::C_W-1:0]   mag  [4];

    logic [qmn_pkg::RS_W-1:0]  rsum [4];
    logic [qmn_pkg::RS_W-1:0]  rmag [4];
    logic [CW-1:0]             n_out [4];

    logic                      r_ov;
    logic [qmn_pkg::OUT_W-1:0] r_out;

    assign en      = !r_ov || i_ready;
    assign o_ready = en;
    assign o_valid = r_ov;
    assign o_data  = r_out;

    // leading one, even shift, mantissa in [2^28, 2^30)
    always_comb begin
        k = '0;
        for (int i = 0; i < qmn_pkg::S_W; i++) begin
            if (i_item.s[i]) begin
                k = qmn_pkg::E_W'(i + 1);
            end
        end
        e_raw     = qmn_pkg::E_W'(30 + qmn_pkg::SH_OFF) - k;
        e         = {e_raw[qmn_pkg::E_W-1:1], 1'b0};
        shl       = qmn_pkg::SHL_W'(i_item.s) << e;
        m0        = shl[qmn_pkg::SH_OFF + qmn_pkg::M_W - 1:qmn_pkg::SH_OFF];
        ctx0.c    = i_item.c;
        ctx0.zero = i_item.s == '0;
        ctx0.t    = qmn_pkg::T_W'(qmn_pkg::T_BASE) - {1'b0, e[qmn_pkg::E_W-1:1]};
        m5        = (qmn_pkg::M_W + 3)'(r_m[0]) * 3'd5;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_sv <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v  <= {r_v[NS-2:0], i_valid};
            r_sv <= r_v[NS-1];
            r_ov <= r_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctx[0] <= ctx0;
            r_m[0]   <= m0;
            for (int i = 1; i < NS; i++) begin
                r_ctx[i] <= r_ctx[i-1];
                r_m[i]   <= r_m[i-1];
            end
            r_y[1] <= qmn_pkg::Y_W'(9 << 28) - qmn_pkg::Y_W'(m5 >> 2);
        end
    end

    for (genvar g = 2; g < NS; g++) begin : g_nr
        logic [63:0] w;
        if ((g - 2) % 3 == 0) begin : g_sq
            assign w = r_y[g-1] * r_y[g-1];
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_aux[g] <= w[62:30];
                    r_y[g]   <= r_y[g-1];
                end
            end
        end else if ((g - 2) % 3 == 1) begin : g_mq
            assign w = r_m[g-1] * r_aux[g-1];
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_aux[g] <= w[62:30];
                    r_y[g]   <= r_y[g-1];
                end
            end
        end else begin : g_upd
            logic [33:0] d;
            assign d = 34'(3) * 34'(1 << 30) - 34'(r_aux[g-1]);
            assign w = r_y[g-1] * d[31:0];
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_aux[g] <= r_aux[g-1];
                    r_y[g]   <= w[62:31];
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            mag[i] = r_ctx[NS-1].c[i][qmn_pkg::C_W-1] ? -r_ctx[NS-1].c[i]
                                                      : r_ctx[NS-1].c[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sctx <= r_ctx[NS-1];
            for (int i = 0; i < 4; i++) begin
                r_sp[i] <= mag[i] * r_y[NS-1];
            end
        end
    end

    // round magnitude half up, then saturate with sign
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            rsum[i] = qmn_pkg::RS_W'(r_sp[i])
                    + (qmn_pkg::RS_W'(1) << (r_sctx.t - qmn_pkg::T_W'(1)));
            rmag[i] = rsum[i] >> r_sctx.t;
            if (r_sctx.zero) begin
                n_out[i] = '0;
            end else if (r_sctx.c[i][qmn_pkg::C_W-1]) begin
                if (rmag[i] > qmn_pkg::RS_W'(1 << (CW - 1))) begin
                    n_out[i] = CW'(1 << (CW - 1));
                end else begin
                    n_out[i] = -rmag[i][CW-1:0];
                end
            end else begin
                if (rmag[i] > qmn_pkg::RS_W'((1 << (CW - 1)) - 1)) begin
                    n_out[i] = CW'((1 << (CW - 1)) - 1);
                end else begin
                    n_out[i] = rmag[i][CW-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_sv) begin
            for (int i = 0; i < 4; i++) begin
                r_out[i*CW +: CW] <= n_out[i];
            end
        end
    end

    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_sv && r_sctx.zero) |=> r_out == '0)
        else $error("zero norm gave non-zero result");

    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sv && !r_sctx.zero) |-> (r_sctx.t > qmn_pkg::T_W'(0) && r_sctx.t < qmn_pkg::T_W'(64)))
        else $error("scale shift out of range");

    a_mant_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[0] && !r_ctx[0].zero) |-> r_m[0][qmn_pkg::M_W-1:qmn_pkg::M_W-2] != 2'b00)
        else $error("mantissa not normalised");

endmodule

>>> sv/quaternion_multiply_normalize.sv
// Top level: normalised Hamilton product of two Q1.14 quaternions.
//
//  channel  dir  tdata fields (lowest bits first)
//  s_*      in   a_w a_x a_y a_z b_w b_x b_y b_z, 16 bits each
//  m_*      out  r_w r_x r_y r_z, 16 bits each
//
// One item per cycle unless m_tready holds the back; data flows front, queue, back.
// The back pipeline length is set by three registered multiplies per Newton step.
// Reset is synchronous, active low, and empties all stages and the queue.
// The front stalls only when the queue is full; the back stalls only on m_tready.
module quaternion_multiply_normalize (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [qmn_pkg::IN_W-1:0]     s_tdata,  // a_w a_x a_y a_z b_w b_x b_y b_z
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [qmn_pkg::OUT_W-1:0]    m_tdata   // r_w r_x r_y r_z
);

    logic           f_valid;
    logic           f_ready;
    qmn_pkg::t_item f_item;
    logic           q_valid;
    logic           q_ready;
    qmn_pkg::t_item q_item;

    qmn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_data  (s_tdata),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_item  (f_item)
    );

    qmn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_item  (f_item),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    qmn_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_item  (q_item),
        .o_valid (m_tvalid),
        .i_ready (m_tready),
        .o_data  (m_tdata)
    );

endmodule
